/* hdl/xml_protocol_tokenizer_core_defines.svh */
// Assertion helpers for the tokenizer core.
// Both expect clk_i and rst_ni in scope.
`ifndef XML_PROTOCOL_TOKENIZER_CORE_DEFINES_SVH
`define XML_PROTOCOL_TOKENIZER_CORE_DEFINES_SVH

// cond at an edge implies prop at the same edge
`define XPT_ASSERT_SAME(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

// cond at an edge implies prop at the next edge
`define XPT_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

/* hdl/xpt_pkg.sv */
package xpt_pkg;

  localparam int unsigned MAX_EV = 3;

  // saturation limit of the entity length
  localparam logic [7:0] RETRACT_MAX = 8'd255;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_DQUOT = 8'h22;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_Q     = 8'h71;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_FF    = 8'h0C;

  // token kind, one-hot
  typedef enum logic [5:0] {
    TK_BEGIN  = 6'b000001,
    TK_KEY    = 6'b000010,
    TK_VAL    = 6'b000100,
    TK_ENTITY = 6'b001000,
    TK_VOID   = 6'b010000,
    TK_END    = 6'b100000
  } tk_e;

  typedef enum logic [3:0] {
    EV_TEXT   = 4'd0,
    EV_NAME   = 4'd1,
    EV_KEY    = 4'd2,
    EV_VALUE  = 4'd3,
    EV_TBEGIN = 4'd4,
    EV_TEND   = 4'd5,
    EV_ENTITY = 4'd6,
    EV_RECEND = 4'd7,
    EV_ABORT  = 4'd8
  } ev_e;

  typedef struct packed {
    tk_e        tk;
    logic [7:0] level;
    logic       in_quote;
    logic [7:0] ent_len;
    logic [7:0] ent_first;
    logic [7:0] ent_second;
  } state_t;

  localparam state_t STATE_RST = '{
    tk:         TK_VOID,
    level:      8'd0,
    in_quote:   1'b0,
    ent_len:    8'd0,
    ent_first:  8'd0,
    ent_second: 8'd0
  };

  typedef struct packed {
    ev_e        kind;
    logic [7:0] data;
    logic [7:0] retract;
  } ev_t;

  // events caused by one input word, slot 0 goes out first
  typedef struct packed {
    logic [1:0]          cnt;
    ev_t [MAX_EV-1:0]    ev;
  } evlist_t;

  // output side status of the event buffer
  typedef struct packed {
    logic valid;
    logic last;
    logic busy;
  } evstat_t;

endpackage

/* hdl/xml_protocol_tokenizer_core.sv */
// Channel  Handshake                 Word
// -------  ------------------------  ----------------------------------------------
// in       in_valid_i / in_stall_o   data_byte_i, abort_i
// out      out_valid_o / out_stall_i event_kind_o, out_byte_o, retract_count_o, last_o
//
// One input word per cycle, unless the input stalls, is decoded straight into
// the event buffer; its events are shown from the next cycle on, one per
// cycle unless the output stalls. A word causing events (at most 3) holds
// the input until its final event leaves; one causing none does not stall it.
// rst_ni clears the tokenizer state and empties the event buffer.
// Input stalls while more than one event is pending, or one is and output stalls.
`include "xml_protocol_tokenizer_core_defines.svh"

module xml_protocol_tokenizer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       abort_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] event_kind_o,
  output logic [7:0] out_byte_o,
  output logic [7:0] retract_count_o,
  output logic       last_o
);
  import xpt_pkg::*;

  // tokenizer state: token kind, level, quote flag, pending entity
  state_t  state_q, state_d;
  state_t  dec_nxt;
  evlist_t dec_evl;
  ev_t     head;
  evstat_t stat;
  logic    accept;

  assign accept = in_valid_i && !stat.busy;

  xpt_decode u_decode (
    .cur_i       (state_q),
    .data_byte_i (data_byte_i),
    .abort_i     (abort_i),
    .nxt_o       (dec_nxt),
    .evl_o       (dec_evl)
  );

  // state advances on every accepted word, events or not
  assign state_d = accept ? dec_nxt : state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RST;
    end else begin
      state_q <= state_d;
    end
  end

  // result register: holds the events of one word
  xpt_evbuf u_evbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .evl_i       (dec_evl),
    .out_stall_i (out_stall_i),
    .head_o      (head),
    .stat_o      (stat)
  );

  assign in_stall_o      = stat.busy;
  assign out_valid_o     = stat.valid;
  assign event_kind_o    = head.kind;
  assign out_byte_o      = head.data;
  assign retract_count_o = head.retract;
  assign last_o          = stat.last;

  // a new word only lands when the buffer is empty or draining its final event
  `XPT_ASSERT_SAME(a_no_overwrite, in_valid_i && !in_stall_o,
    !out_valid_o || (last_o && !out_stall_i), "word accepted over pending events")

  // abort gives one single aborted event
  `XPT_ASSERT_NEXT(a_abort_event, in_valid_i && !in_stall_o && abort_i,
    out_valid_o && (event_kind_o == EV_ABORT) && last_o, "abort event missing")

  // record end is always the final event of its word
  `XPT_ASSERT_SAME(a_recend_last, out_valid_o && (event_kind_o == EV_RECEND),
    last_o, "record end not last")

endmodule

/* hdl/xpt_decode.sv */
module xpt_decode (
  input  xpt_pkg::state_t  cur_i,
  input  logic [7:0]       data_byte_i,
  input  logic             abort_i,
  output xpt_pkg::state_t  nxt_o,
  output xpt_pkg::evlist_t evl_o
);
  import xpt_pkg::*;

  // text byte bookkeeping while an entity is pending
  function automatic state_t ent_bump(state_t s, logic [7:0] b);
    state_t r;
    r = s;
    if (s.tk == TK_ENTITY) begin
      if (s.ent_len != RETRACT_MAX) r.ent_len = s.ent_len + 8'd1;
      if (r.ent_len == 8'd2) r.ent_first = b;
      else if (r.ent_len == 8'd3) r.ent_second = b;
    end
    return r;
  endfunction

  function automatic ev_e close_kind(tk_e k);
    ev_e r;
    case (k)
      TK_BEGIN: r = EV_NAME;
      TK_KEY:   r = EV_KEY;
      default:  r = EV_VALUE;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] lvl_dec(logic [7:0] l);
    return (l != 8'd0) ? l - 8'd1 : l;
  endfunction

  always_comb begin
    state_t     nxt;
    evlist_t    el;
    logic [1:0] n;
    logic       ws;
    logic       special;
    logic [7:0] b;
    logic [7:0] rep;
    logic       hit;

    b       = data_byte_i;
    nxt     = cur_i;
    el      = '0;
    n       = 2'd0;
    rep     = 8'd0;
    hit     = 1'b1;
    ws      = b inside {CH_SP, CH_TAB, CH_LF, CH_CR, CH_FF};
    special = ws || (b inside {CH_LT, CH_EQ, CH_SLASH, CH_GT});

    if (abort_i) begin
      el.ev[n] = '{kind: EV_ABORT, data: 8'd0, retract: 8'd0};
      n        = n + 2'd1;
      nxt      = STATE_RST;
    end else if (cur_i.in_quote && special) begin
      el.ev[n] = '{kind: EV_TEXT, data: b, retract: 8'd0};
      n        = n + 2'd1;
      nxt      = ent_bump(cur_i, b);
    end else if (b == CH_LT) begin
      if (cur_i.level != 8'hFF) nxt.level = cur_i.level + 8'd1;
      nxt.tk = TK_BEGIN;
    end else if (ws) begin
      if (cur_i.tk == TK_BEGIN) begin
        el.ev[n] = '{kind: EV_NAME, data: 8'd0, retract: 8'd0};
        n        = n + 2'd1;
        nxt.tk   = TK_KEY;
      end
    end else if (b == CH_EQ) begin
      el.ev[n] = '{kind: close_kind(cur_i.tk), data: 8'd0, retract: 8'd0};
      n        = n + 2'd1;
      nxt.tk   = TK_VAL;
    end else if (b == CH_SLASH) begin
      if (cur_i.tk == TK_BEGIN) begin
        nxt.tk    = TK_END;
        nxt.level = lvl_dec(lvl_dec(cur_i.level));
      end else begin
        nxt.level = lvl_dec(cur_i.level);
      end
    end else if (b == CH_GT) begin
      if (cur_i.tk == TK_END) begin
        el.ev[n] = '{kind: EV_NAME, data: 8'd0, retract: 8'd0};
        n        = n + 2'd1;
        el.ev[n] = '{kind: EV_TEND, data: 8'd0, retract: 8'd0};
        n        = n + 2'd1;
      end else begin
        if (cur_i.tk == TK_VAL || cur_i.tk == TK_BEGIN) begin
          el.ev[n] = '{kind: close_kind(cur_i.tk), data: 8'd0, retract: 8'd0};
          n        = n + 2'd1;
        end
        el.ev[n] = '{kind: EV_TBEGIN, data: 8'd0, retract: 8'd0};
        n        = n + 2'd1;
      end
      nxt.tk = TK_VOID;
      if (cur_i.level == 8'd0) begin
        el.ev[n] = '{kind: EV_RECEND, data: 8'd0, retract: 8'd0};
        n        = n + 2'd1;
        nxt      = STATE_RST;
      end
    end else if (b == CH_AMP) begin
      el.ev[n]       = '{kind: EV_TEXT, data: b, retract: 8'd0};
      n              = n + 2'd1;
      nxt.tk         = TK_ENTITY;
      nxt.ent_len    = 8'd1;
      nxt.ent_first  = 8'd0;
      nxt.ent_second = 8'd0;
    end else if (b == CH_SEMI) begin
      if (cur_i.tk == TK_ENTITY) begin
        case (cur_i.ent_first)
          CH_L:    rep = CH_LT;
          CH_G:    rep = CH_GT;
          CH_A:    rep = (cur_i.ent_second == CH_M) ? CH_AMP : CH_APOS;
          CH_Q:    rep = CH_DQUOT;
          default: hit = 1'b0;
        endcase
        if (hit) begin
          el.ev[n] = '{kind: EV_ENTITY, data: rep, retract: cur_i.ent_len};
          n        = n + 2'd1;
        end else begin
          el.ev[n] = '{kind: EV_TEXT, data: b, retract: 8'd0};
          n        = n + 2'd1;
          nxt      = ent_bump(cur_i, b);
        end
        nxt.tk = TK_VAL;
      end else begin
        el.ev[n] = '{kind: EV_TEXT, data: b, retract: 8'd0};
        n        = n + 2'd1;
      end
    end else if (b == CH_DQUOT) begin
      nxt.in_quote = !cur_i.in_quote;
      // closing quote ends a value
      if (cur_i.in_quote && cur_i.tk == TK_VAL) begin
        el.ev[n] = '{kind: EV_VALUE, data: 8'd0, retract: 8'd0};
        n        = n + 2'd1;
        nxt.tk   = TK_KEY;
      end
    end else begin
      el.ev[n] = '{kind: EV_TEXT, data: b, retract: 8'd0};
      n        = n + 2'd1;
      nxt      = ent_bump(cur_i, b);
    end

    el.cnt = n;
    nxt_o  = nxt;
    evl_o  = el;
  end

endmodule

/* hdl/xpt_evbuf.sv */
module xpt_evbuf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  xpt_pkg::evlist_t evl_i,
  input  logic             out_stall_i,
  output xpt_pkg::ev_t     head_o,
  output xpt_pkg::evstat_t stat_o
);
  import xpt_pkg::*;

  logic [1:0]       cnt_q, cnt_d;
  ev_t [MAX_EV-1:0] ev_q, ev_d;
  logic             take;

  assign take = (cnt_q != 2'd0) && !out_stall_i;

  always_comb begin
    cnt_d = cnt_q;
    ev_d  = ev_q;
    if (load_i) begin
      cnt_d = evl_i.cnt;
      ev_d  = evl_i.ev;
    end else if (take) begin
      // shift toward the head
      cnt_d    = cnt_q - 2'd1;
      ev_d[0]  = ev_q[1];
      ev_d[1]  = ev_q[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_q <= ev_d;
  end

  assign head_o       = ev_q[0];
  assign stat_o.valid = (cnt_q != 2'd0);
  assign stat_o.last  = (cnt_q == 2'd1);
  // full unless empty or the final event leaves this cycle
  assign stat_o.busy  = (cnt_q > 2'd1) || ((cnt_q == 2'd1) && out_stall_i);

endmodule
